[rtl/core/uhp_pkg.sv]
// package for the unified diff hunk parser
// shared byte codes, header steps, line kinds and the token word type
// no dependencies
`timescale 1ns / 1ps

package uhp_pkg;

    localparam int NUMBER_BITS_DEF = 32;
    localparam int PORT_BITS       = 32;
    localparam int QUEUE_DEPTH     = 4;
    localparam int QPTR_BITS       = $clog2(QUEUE_DEPTH);

    // byte codes
    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_AT    = 8'h40;

    // line kinds, also used as the body line class
    localparam logic [2:0] KIND_HEADER = 3'd0;
    localparam logic [2:0] KIND_SAME   = 3'd1;
    localparam logic [2:0] KIND_DEL    = 3'd2;
    localparam logic [2:0] KIND_INS    = 3'd3;
    localparam logic [2:0] KIND_BAD    = 3'd4;
    localparam logic [2:0] CLS_NONE    = 3'd0;

    // header recogniser steps for "@@ -a,b +c,d @@"
    localparam logic [3:0] HS_AT0      = 4'd0;
    localparam logic [3:0] HS_AT1      = 4'd1;
    localparam logic [3:0] HS_SP0      = 4'd2;
    localparam logic [3:0] HS_MINUS    = 4'd3;
    localparam logic [3:0] HS_OS_FIRST = 4'd4;
    localparam logic [3:0] HS_OS_MORE  = 4'd5;
    localparam logic [3:0] HS_OC_FIRST = 4'd6;
    localparam logic [3:0] HS_OC_MORE  = 4'd7;
    localparam logic [3:0] HS_PLUS     = 4'd8;
    localparam logic [3:0] HS_NS_FIRST = 4'd9;
    localparam logic [3:0] HS_NS_MORE  = 4'd10;
    localparam logic [3:0] HS_NC_FIRST = 4'd11;
    localparam logic [3:0] HS_NC_MORE  = 4'd12;
    localparam logic [3:0] HS_AT2      = 4'd13;
    localparam logic [3:0] HS_AT3      = 4'd14;
    localparam logic [3:0] HS_DONE     = 4'd15;

    // classified byte as it travels from front to back
    typedef struct packed {
        logic       nl;
        logic       digit;
        logic       at;
        logic       space;
        logic       minus;
        logic       plus;
        logic       comma;
        logic [3:0] dval;
    } t_token;

    typedef enum logic [1:0] {
        MODE_HEADER = 2'b01,
        MODE_BODY   = 2'b10
    } t_mode;

endpackage

[rtl/core/unified_diff_hunk_parser_unit.sv]
// unified diff hunk parser: one text byte a cycle in while o_stall is low, one word per hunk header or body line out
// a newline word passes the token queue and the back end's output register before it shows on o_valid
// the back end takes one token per cycle, but holds a newline while the output register is stalled
// o_stall rises only while the four-word token queue is full
// reset: synchronous, active low; expects a header line, counts back to 1, no clearing pass
// depends on uhp_pkg, uhp_front, uhp_queue, uhp_back
`timescale 1ns / 1ps

module unified_diff_hunk_parser_unit
    import uhp_pkg::*;
#(
    parameter int NUMBER_BITS = NUMBER_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // text byte channel
    input  logic                 i_valid,
    input  logic [7:0]           i_text_byte,
    output logic                 o_stall,
    // line result channel
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [2:0]           o_line_kind,
    output logic [PORT_BITS-1:0] o_before_start,
    output logic [PORT_BITS-1:0] o_before_count,
    output logic [PORT_BITS-1:0] o_after_start,
    output logic [PORT_BITS-1:0] o_after_count,
    output logic                 o_hunk_done
);

    // front to queue
    logic   w_push;
    t_token w_push_token;
    logic   w_queue_full;

    // queue to back
    logic   w_tok_valid;
    t_token w_tok;
    logic   w_pop;

    // classify each byte as it is taken
    uhp_front u_front (
        .i_valid      (i_valid),
        .i_text_byte  (i_text_byte),
        .i_queue_full (w_queue_full),
        .o_stall      (o_stall),
        .o_push       (w_push),
        .o_token      (w_push_token)
    );

    // decouples byte intake from a result stall at the output
    uhp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_token (w_push_token),
        .i_pop   (w_pop),
        .o_full  (w_queue_full),
        .o_valid (w_tok_valid),
        .o_token (w_tok)
    );

    // header parse, body counting, output register
    // a newline word is only taken when the output register can accept a result
    uhp_back #(
        .NUMBER_BITS (NUMBER_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_tok_valid    (w_tok_valid),
        .i_token        (w_tok),
        .o_pop          (w_pop),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_line_kind    (o_line_kind),
        .o_before_start (o_before_start),
        .o_before_count (o_before_count),
        .o_after_start  (o_after_start),
        .o_after_count  (o_after_count),
        .o_hunk_done    (o_hunk_done)
    );

endmodule

[rtl/core/uhp_front.sv]
// front end: takes text bytes and classifies them into token words
// depends on uhp_pkg
`timescale 1ns / 1ps

module uhp_front
    import uhp_pkg::*;
(
    input  logic       i_valid,
    input  logic [7:0] i_text_byte,
    input  logic       i_queue_full,
    output logic       o_stall,
    output logic       o_push,
    output t_token     o_token
);

    logic [7:0] w_diff;

    assign o_stall = i_queue_full;
    assign o_push  = i_valid && !i_queue_full;
    assign w_diff  = i_text_byte - CH_ZERO;

    always_comb begin
        o_token.nl    = (i_text_byte == CH_NL);
        o_token.digit = (i_text_byte >= CH_ZERO) && (i_text_byte <= CH_NINE);
        o_token.at    = (i_text_byte == CH_AT);
        o_token.space = (i_text_byte == CH_SPACE);
        o_token.minus = (i_text_byte == CH_MINUS);
        o_token.plus  = (i_text_byte == CH_PLUS);
        o_token.comma = (i_text_byte == CH_COMMA);
        o_token.dval  = w_diff[3:0];
    end

endmodule

[rtl/core/uhp_queue.sv]
// short token queue between front and back
// depends on uhp_pkg
`timescale 1ns / 1ps

module uhp_queue
    import uhp_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_token i_token,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_valid,
    output t_token o_token
);

    t_token               r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_BITS-1:0] r_rd_ptr, n_rd_ptr;
    logic [QPTR_BITS:0]   r_count,  n_count;
    logic                 w_do_push, w_do_pop;

    assign o_full    = (r_count == (QPTR_BITS + 1)'(QUEUE_DEPTH));
    assign o_valid   = (r_count != '0);
    assign o_token   = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = w_do_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = w_do_pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_do_pop && !w_do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_token;
        end
    end

endmodule

[rtl/core/uhp_back.sv]
// back end: header recogniser, body line counter and output register
// depends on uhp_pkg
`timescale 1ns / 1ps

module uhp_back
    import uhp_pkg::*;
#(
    parameter int NUMBER_BITS = NUMBER_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_tok_valid,
    input  t_token               i_token,
    output logic                 o_pop,
    input  logic                 i_stall,
    output logic                 o_valid,
    output logic [2:0]           o_line_kind,
    output logic [PORT_BITS-1:0] o_before_start,
    output logic [PORT_BITS-1:0] o_before_count,
    output logic [PORT_BITS-1:0] o_after_start,
    output logic [PORT_BITS-1:0] o_after_count,
    output logic                 o_hunk_done
);

    localparam int NW = (NUMBER_BITS >= 32) ? 32 : NUMBER_BITS;

    function automatic logic [NW-1:0] f_adjust(input logic [NW-1:0] start,
                                               input logic [NW-1:0] count);
        logic [NW-1:0] res;
        res = start;
        if (start != '0 && count == '0 && !(&start)) begin
            res = start + 1'b1;
        end
        return res;
    endfunction

    t_mode          r_mode, n_mode;
    logic [3:0]     r_step, n_step;
    logic [2:0]     r_cls, n_cls;
    logic [NW-1:0]  r_acc, n_acc;
    logic [NW-1:0]  r_old_start, n_old_start, r_old_count, n_old_count;
    logic [NW-1:0]  r_new_start, n_new_start, r_new_count, n_new_count;
    logic [NW-1:0]  r_old_left, n_old_left, r_new_left, n_new_left;
    logic           r_out_valid, n_out_valid;
    logic [2:0]     r_kind, n_kind;
    logic [NW-1:0]  r_bs, n_bs, r_bc, n_bc, r_as, n_as, r_ac, n_ac;
    logic           r_done, n_done;

    logic            w_out_free;
    logic [NW+3:0]   w_mac;
    logic [NW-1:0]   w_acc_sat;
    logic            w_first_digit, w_more_digit;
    logic            w_hdr_body;
    logic            w_bad_line;
    logic [NW-1:0]   w_old_dec, w_new_dec;

    assign w_out_free = !r_out_valid || !i_stall;
    assign o_pop      = i_tok_valid && (!i_token.nl || w_out_free);

    // times-ten accumulate with saturation
    assign w_mac = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1)
                 + (NW + 4)'(i_token.dval);
    assign w_acc_sat = (|w_mac[NW+3:NW]) ? '1 : w_mac[NW-1:0];

    assign w_first_digit = i_token.digit &&
        (r_step == HS_OS_FIRST || r_step == HS_OC_FIRST ||
         r_step == HS_NS_FIRST || r_step == HS_NC_FIRST);
    assign w_more_digit = i_token.digit &&
        (r_step == HS_OS_MORE || r_step == HS_OC_MORE ||
         r_step == HS_NS_MORE || r_step == HS_NC_MORE);

    assign w_hdr_body = (r_old_count != '0) || (r_new_count != '0);

    assign w_bad_line = (r_cls == KIND_SAME && (r_old_left == '0 || r_new_left == '0))
                     || (r_cls == KIND_DEL && r_old_left == '0)
                     || (r_cls == KIND_INS && r_new_left == '0)
                     || (r_cls == CLS_NONE) || (r_cls == KIND_BAD);

    assign w_old_dec = (r_cls != KIND_INS) ? r_old_left - 1'b1 : r_old_left;
    assign w_new_dec = (r_cls != KIND_DEL) ? r_new_left - 1'b1 : r_new_left;

    always_comb begin
        n_mode      = r_mode;
        n_step      = r_step;
        n_cls       = r_cls;
        n_acc       = r_acc;
        n_old_start = r_old_start;
        n_old_count = r_old_count;
        n_new_start = r_new_start;
        n_new_count = r_new_count;
        n_old_left  = r_old_left;
        n_new_left  = r_new_left;
        n_out_valid = r_out_valid && i_stall;
        n_kind      = r_kind;
        n_bs        = r_bs;
        n_bc        = r_bc;
        n_as        = r_as;
        n_ac        = r_ac;
        n_done      = r_done;

        if (o_pop) begin
            if (i_token.nl) begin
                n_step = HS_AT0;
                n_acc  = '0;
                n_cls  = CLS_NONE;
            end
            if (r_mode == MODE_HEADER) begin
                if (i_token.nl) begin
                    if (r_cls != KIND_BAD && r_step == HS_DONE) begin
                        n_old_left  = r_old_count;
                        n_new_left  = r_new_count;
                        n_mode      = w_hdr_body ? MODE_BODY : MODE_HEADER;
                        n_out_valid = 1'b1;
                        n_kind      = KIND_HEADER;
                        n_bs        = f_adjust(r_old_start, r_old_count);
                        n_bc        = r_old_count;
                        n_as        = f_adjust(r_new_start, r_new_count);
                        n_ac        = r_new_count;
                        n_done      = !w_hdr_body;
                    end
                end else if (r_cls != KIND_BAD) begin
                    if (w_first_digit) begin
                        n_acc  = NW'(i_token.dval);
                        n_step = r_step + 1'b1;
                    end else if (w_more_digit) begin
                        n_acc = w_acc_sat;
                    end else begin
                        // any byte that fits nowhere rejects the line
                        n_cls = KIND_BAD;
                        case (r_step)
                            HS_AT0, HS_AT1, HS_AT2, HS_AT3: begin
                                if (i_token.at) begin
                                    n_step = r_step + 1'b1;
                                    n_cls  = r_cls;
                                end
                            end
                            HS_SP0: begin
                                if (i_token.space) begin
                                    n_step = HS_MINUS;
                                    n_cls  = r_cls;
                                end
                            end
                            HS_MINUS: begin
                                if (i_token.minus) begin
                                    n_step = HS_OS_FIRST;
                                    n_cls  = r_cls;
                                end
                            end
                            HS_PLUS: begin
                                if (i_token.plus) begin
                                    n_step = HS_NS_FIRST;
                                    n_cls  = r_cls;
                                end
                            end
                            HS_OS_MORE: begin
                                if (i_token.comma) begin
                                    n_old_start = r_acc;
                                    n_step      = HS_OC_FIRST;
                                    n_cls       = r_cls;
                                end else if (i_token.space) begin
                                    n_old_start = r_acc;
                                    n_old_count = NW'(1);
                                    n_step      = HS_PLUS;
                                    n_cls       = r_cls;
                                end
                            end
                            HS_OC_MORE: begin
                                if (i_token.space) begin
                                    n_old_count = r_acc;
                                    n_step      = HS_PLUS;
                                    n_cls       = r_cls;
                                end
                            end
                            HS_NS_MORE: begin
                                if (i_token.comma) begin
                                    n_new_start = r_acc;
                                    n_step      = HS_NC_FIRST;
                                    n_cls       = r_cls;
                                end else if (i_token.space) begin
                                    n_new_start = r_acc;
                                    n_new_count = NW'(1);
                                    n_step      = HS_AT2;
                                    n_cls       = r_cls;
                                end
                            end
                            HS_NC_MORE: begin
                                if (i_token.space) begin
                                    n_new_count = r_acc;
                                    n_step      = HS_AT2;
                                    n_cls       = r_cls;
                                end
                            end
                            default: begin
                                n_cls = KIND_BAD;
                            end
                        endcase
                    end
                end
            end else begin
                if (!i_token.nl) begin
                    if (r_cls == CLS_NONE) begin
                        if (i_token.space) begin
                            n_cls = KIND_SAME;
                        end else if (i_token.minus) begin
                            n_cls = KIND_DEL;
                        end else if (i_token.plus) begin
                            n_cls = KIND_INS;
                        end else begin
                            n_cls = KIND_BAD;
                        end
                    end
                end else begin
                    n_out_valid = 1'b1;
                    n_bs        = '0;
                    n_bc        = '0;
                    n_as        = '0;
                    n_ac        = '0;
                    if (w_bad_line) begin
                        n_mode = MODE_HEADER;
                        n_kind = KIND_BAD;
                        n_done = 1'b0;
                    end else begin
                        n_old_left = w_old_dec;
                        n_new_left = w_new_dec;
                        n_kind     = r_cls;
                        n_done     = (w_old_dec == '0) && (w_new_dec == '0);
                        if (w_old_dec == '0 && w_new_dec == '0) begin
                            n_mode = MODE_HEADER;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_HEADER;
            r_step      <= HS_AT0;
            r_cls       <= CLS_NONE;
            r_acc       <= '0;
            r_old_start <= '0;
            r_old_count <= NW'(1);
            r_new_start <= '0;
            r_new_count <= NW'(1);
            r_old_left  <= '0;
            r_new_left  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_mode      <= n_mode;
            r_step      <= n_step;
            r_cls       <= n_cls;
            r_acc       <= n_acc;
            r_old_start <= n_old_start;
            r_old_count <= n_old_count;
            r_new_start <= n_new_start;
            r_new_count <= n_new_count;
            r_old_left  <= n_old_left;
            r_new_left  <= n_new_left;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_bs   <= n_bs;
        r_bc   <= n_bc;
        r_as   <= n_as;
        r_ac   <= n_ac;
        r_done <= n_done;
    end

    assign o_valid        = r_out_valid;
    assign o_line_kind    = r_kind;
    assign o_before_start = PORT_BITS'(r_bs);
    assign o_before_count = PORT_BITS'(r_bc);
    assign o_after_start  = PORT_BITS'(r_as);
    assign o_after_count  = PORT_BITS'(r_ac);
    assign o_hunk_done    = r_done;

endmodule

[sim/tb_top.sv]
// testbench for unified_diff_hunk_parser_unit: patch text bytes in, one word per hunk header or body line out
// a directed list of lines, then random hunks and noise, each word checked against a hand-typed word or a predictor
// depends on uhp_pkg and unified_diff_hunk_parser_unit
`timescale 1ns / 1ps

module tb_top;
    import uhp_pkg::*;

    localparam logic [31:0] NUM_MAX     = 32'hFFFF_FFFF;
    localparam int          RANDOM_BYTES = 570;
    localparam int          LONG_HOLD    = 150;
    localparam int          CYCLE_LIMIT  = 300000;
    localparam int          TAIL_NONE    = -1;

    // one word of the line result channel
    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] before_start;
        logic [31:0] before_count;
        logic [31:0] after_start;
        logic [31:0] after_count;
        logic        done;
    } t_line_word;

    // one directed line: text, an optional extra byte before the newline,
    // and a word typed in by hand where it is obvious
    typedef struct {
        string      text;
        int         tail;
        bit         typed;
        t_line_word word;
    } t_dir_line;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic [7:0]  i_text_byte;
    logic        o_stall;
    logic        o_valid;
    logic        i_stall;
    logic [2:0]  o_line_kind;
    logic [31:0] o_before_start;
    logic [31:0] o_before_count;
    logic [31:0] o_after_start;
    logic [31:0] o_after_count;
    logic        o_hunk_done;

    unified_diff_hunk_parser_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_text_byte    (i_text_byte),
        .o_stall        (o_stall),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_line_kind    (o_line_kind),
        .o_before_start (o_before_start),
        .o_before_count (o_before_count),
        .o_after_start  (o_after_start),
        .o_after_count  (o_after_count),
        .o_hunk_done    (o_hunk_done)
    );

    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // words still owed by the block, oldest first
    t_line_word  line_words_due[$];
    t_dir_line   dir_lines[$];
    logic [7:0]  line_bytes[$];
    int          mismatches = 0;
    int          cycles     = 0;
    int          bytes_sent = 0;
    bit          tx_idle_on = 1'b1;
    bit          rx_idle_on = 1'b1;
    bit          long_hold_req = 1'b0;

    // predictor state, a copy of the parser's own
    bit          p_in_body;
    logic [3:0]  p_step;
    logic [31:0] p_acc;
    logic [31:0] p_old_start, p_old_count, p_new_start, p_new_count;
    logic [31:0] p_old_left, p_new_left;
    logic [2:0]  p_cls;

    function automatic t_line_word mk_word(logic [2:0] k, logic [31:0] bs, logic [31:0] bc,
                                           logic [31:0] as_, logic [31:0] ac, logic d);
        t_line_word w;
        w.kind         = k;
        w.before_start = bs;
        w.before_count = bc;
        w.after_start  = as_;
        w.after_count  = ac;
        w.done         = d;
        return w;
    endfunction

    // times-ten accumulate, held at the top of the range
    function automatic logic [31:0] acc_digit(logic [31:0] a, logic [3:0] d);
        logic [63:0] s;
        s = {32'd0, a} * 64'd10 + {60'd0, d};
        return (s > {32'd0, NUM_MAX}) ? NUM_MAX : s[31:0];
    endfunction

    // a start with a zero count names the line before, so it moves up by one
    function automatic logic [31:0] bump_start(logic [31:0] s, logic [31:0] c);
        if (s != 0 && c == 0)
            return (s == NUM_MAX) ? NUM_MAX : s + 1;
        return s;
    endfunction

    // append one byte to the line being built
    task automatic add_byte(input logic [7:0] b);
        line_bytes = {line_bytes, b};
    endtask

    task automatic start_line();
        p_step = HS_AT0;
        p_acc  = '0;
        p_cls  = CLS_NONE;
    endtask

    task automatic reset_predictor();
        p_in_body   = 1'b0;
        p_old_start = '0;
        p_old_count = 32'd1;
        p_new_start = '0;
        p_new_count = 32'd1;
        p_old_left  = '0;
        p_new_left  = '0;
        start_line();
    endtask

    // one byte through the predicted parser, giving the word it causes if any
    task automatic hunk_parse_byte(input logic [7:0] b, output bit has, output t_line_word w);
        logic       digit;
        bit         rej;
        logic [2:0] c;
        has   = 1'b0;
        w     = '0;
        rej   = 1'b0;
        digit = (b >= CH_ZERO) && (b <= CH_NINE);
        if (!p_in_body) begin
            if (b != CH_NL) begin
                if (p_cls != KIND_BAD) begin
                    if (digit && (p_step == HS_OS_FIRST || p_step == HS_OC_FIRST ||
                                  p_step == HS_NS_FIRST || p_step == HS_NC_FIRST)) begin
                        p_acc  = {28'd0, b[3:0]};
                        p_step = p_step + 4'd1;
                    end else if (digit && (p_step == HS_OS_MORE || p_step == HS_OC_MORE ||
                                           p_step == HS_NS_MORE || p_step == HS_NC_MORE)) begin
                        p_acc = acc_digit(p_acc, b[3:0]);
                    end else begin
                        case (p_step)
                            HS_AT0, HS_AT1, HS_AT2, HS_AT3: begin
                                if (b == CH_AT) p_step = p_step + 4'd1;
                                else rej = 1'b1;
                            end
                            HS_SP0: begin
                                if (b == CH_SPACE) p_step = HS_MINUS;
                                else rej = 1'b1;
                            end
                            HS_MINUS: begin
                                if (b == CH_MINUS) p_step = HS_OS_FIRST;
                                else rej = 1'b1;
                            end
                            HS_PLUS: begin
                                if (b == CH_PLUS) p_step = HS_NS_FIRST;
                                else rej = 1'b1;
                            end
                            HS_OS_MORE: begin
                                if (b == CH_COMMA) begin
                                    p_old_start = p_acc;
                                    p_step      = HS_OC_FIRST;
                                end else if (b == CH_SPACE) begin
                                    p_old_start = p_acc;
                                    p_old_count = 32'd1;
                                    p_step      = HS_PLUS;
                                end else rej = 1'b1;
                            end
                            HS_OC_MORE: begin
                                if (b == CH_SPACE) begin
                                    p_old_count = p_acc;
                                    p_step      = HS_PLUS;
                                end else rej = 1'b1;
                            end
                            HS_NS_MORE: begin
                                if (b == CH_COMMA) begin
                                    p_new_start = p_acc;
                                    p_step      = HS_NC_FIRST;
                                end else if (b == CH_SPACE) begin
                                    p_new_start = p_acc;
                                    p_new_count = 32'd1;
                                    p_step      = HS_AT2;
                                end else rej = 1'b1;
                            end
                            HS_NC_MORE: begin
                                if (b == CH_SPACE) begin
                                    p_new_count = p_acc;
                                    p_step      = HS_AT2;
                                end else rej = 1'b1;
                            end
                            default: rej = 1'b1;
                        endcase
                        if (rej) p_cls = KIND_BAD;
                    end
                end
            end else if (p_cls == KIND_BAD || p_step != HS_DONE) begin
                // rejected header line, silently dropped
                start_line();
            end else begin
                start_line();
                p_old_left = p_old_count;
                p_new_left = p_new_count;
                p_in_body  = (p_old_left != 0 || p_new_left != 0);
                has = 1'b1;
                w = mk_word(KIND_HEADER, bump_start(p_old_start, p_old_count), p_old_count,
                            bump_start(p_new_start, p_new_count), p_new_count, !p_in_body);
            end
        end else if (b != CH_NL) begin
            // only the first byte of a body line matters
            if (p_cls == CLS_NONE) begin
                case (b)
                    CH_SPACE: p_cls = KIND_SAME;
                    CH_MINUS: p_cls = KIND_DEL;
                    CH_PLUS:  p_cls = KIND_INS;
                    default:  p_cls = KIND_BAD;
                endcase
            end
        end else begin
            c = p_cls;
            start_line();
            has = 1'b1;
            if ((c == KIND_SAME && (p_old_left == 0 || p_new_left == 0)) ||
                (c == KIND_DEL && p_old_left == 0) || (c == KIND_INS && p_new_left == 0) ||
                c == CLS_NONE || c >= KIND_BAD) begin
                // empty, bad lead byte or overdrawn count: back to header mode
                p_in_body = 1'b0;
                w = mk_word(KIND_BAD, '0, '0, '0, '0, 1'b0);
            end else begin
                if (c != KIND_INS) p_old_left = p_old_left - 1;
                if (c != KIND_DEL) p_new_left = p_new_left - 1;
                p_in_body = (p_old_left != 0 || p_new_left != 0);
                w = mk_word(c, '0, '0, '0, '0, !p_in_body);
            end
        end
    endtask

    // offer one byte, hold it until taken, then book the word it causes
    task automatic put_byte(input logic [7:0] b, input bit typed, input t_line_word tw);
        int         gap;
        bit         has;
        t_line_word pw;
        if (tx_idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 8);
            @(negedge i_clk);
            i_valid     <= 1'b0;
            i_text_byte <= 8'($urandom_range(0, 255));
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid     <= 1'b1;
        i_text_byte <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        bytes_sent++;
        hunk_parse_byte(b, has, pw);
        if (typed) line_words_due = {line_words_due, tw};
        else if (has) line_words_due = {line_words_due, pw};
    endtask

    // the collected line plus its newline; a typed word stands for the newline's result
    task automatic send_line(input bit typed, input t_line_word tw);
        foreach (line_bytes[k]) put_byte(line_bytes[k], 1'b0, '0);
        put_byte(CH_NL, typed, tw);
        line_bytes.delete();
    endtask

    task automatic push_str(input string s);
        for (int k = 0; k < s.len(); k++) add_byte(s[k]);
    endtask

    function automatic logic [7:0] any_text_byte();
        logic [7:0] v;
        v = 8'($urandom_range(0, 255));
        return (v == CH_NL) ? ~v : v;
    endfunction

    task automatic push_content();
        int n;
        n = $urandom_range(0, 5);
        repeat (n) add_byte(any_text_byte());
    endtask

    // mostly small starts, some full range, a few long digit runs that may saturate
    task automatic push_number();
        int sel;
        int n;
        sel = $urandom_range(0, 9);
        if (sel < 7) begin
            push_str($sformatf("%0d", $urandom_range(0, 20)));
        end else if (sel < 9) begin
            push_str($sformatf("%0d", $urandom));
        end else begin
            n = $urandom_range(10, 14);
            repeat (n) add_byte(8'(CH_ZERO + $urandom_range(0, 9)));
        end
    endtask

    function automatic int unsigned pick_count();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 17) return $urandom_range(0, 4);
        if (sel < 19) return $urandom_range(5, 12);
        return $urandom;
    endfunction

    // a header, sometimes damaged, then a body that mostly fits its counts
    task automatic random_hunk();
        int unsigned oc, nc, ol, nl_, lines;
        int          k;
        bit          broken;
        push_str("@@ -");
        push_number();
        if ($urandom_range(0, 3) == 0) oc = 1;
        else begin
            oc = pick_count();
            push_str($sformatf(",%0d", oc));
        end
        push_str(" +");
        push_number();
        if ($urandom_range(0, 3) == 0) nc = 1;
        else begin
            nc = pick_count();
            push_str($sformatf(",%0d", nc));
        end
        push_str(" @@");
        broken = ($urandom_range(0, 9) == 0);
        if (broken) begin
            case ($urandom_range(0, 2))
                0: line_bytes[$urandom_range(0, line_bytes.size() - 1)] = any_text_byte();
                1: add_byte(any_text_byte());
                default: line_bytes.delete($urandom_range(0, line_bytes.size() - 1));
            endcase
        end
        send_line(1'b0, '0);
        ol    = broken ? 0 : oc;
        nl_   = broken ? 0 : nc;
        lines = 0;
        while ((ol > 0 || nl_ > 0) && lines < 12) begin
            lines++;
            if ($urandom_range(0, 24) == 0) begin
                // break the hunk: empty line, odd lead byte, or an overdrawn kind
                case ($urandom_range(0, 2))
                    0: ;
                    1: add_byte(any_text_byte());
                    default: add_byte(ol == 0 ? CH_MINUS : (nl_ == 0 ? CH_PLUS : CH_SPACE));
                endcase
                push_content();
                send_line(1'b0, '0);
                ol  = 0;
                nl_ = 0;
            end else begin
                if (ol > 0 && nl_ > 0) k = $urandom_range(0, 2);
                else if (ol > 0) k = 1;
                else k = 2;
                case (k)
                    0: begin
                        add_byte(CH_SPACE);
                        ol--;
                        nl_--;
                    end
                    1: begin
                        add_byte(CH_MINUS);
                        ol--;
                    end
                    default: begin
                        add_byte(CH_PLUS);
                        nl_--;
                    end
                endcase
                push_content();
                send_line(1'b0, '0);
            end
        end
    endtask

    task automatic add_line(input string text, input int tail, input bit typed,
                            input t_line_word w);
        t_dir_line r;
        r.text  = text;
        r.tail  = tail;
        r.typed = typed;
        r.word  = w;
        dir_lines = {dir_lines, r};
    endtask

    // result side: random stall bursts, and one long hold-off on request
    initial begin
        int n;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                i_stall <= 1'b1;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
                long_hold_req = 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
                i_stall <= 1'b1;
                n = $urandom_range(1, 8);
                repeat (n - 1) @(negedge i_clk);
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // word checker: every accepted word against the oldest one owed
    always @(posedge i_clk) begin : word_check
        t_line_word got;
        t_line_word want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = mk_word(o_line_kind, o_before_start, o_before_count,
                          o_after_start, o_after_count, o_hunk_done);
            if (line_words_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: kind %0d bs %0d bc %0d as %0d ac %0d done %0d",
                             got.kind, got.before_start, got.before_count,
                             got.after_start, got.after_count, got.done);
            end else begin
                want = line_words_due.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %0d/%0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d/%0d",
                                 want.kind, want.before_start, want.before_count,
                                 want.after_start, want.after_count, want.done,
                                 got.kind, got.before_start, got.before_count,
                                 got.after_start, got.after_count, got.done);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    initial begin : main_seq
        int  sel;
        int  dir_bytes;
        int  rb;
        int  n;
        bit  hold_asked;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_text_byte = 8'd0;
        hold_asked  = 1'b0;
        reset_predictor();

        // directed lines; typed words are the ones readable at a glance
        add_line("--- a/f", TAIL_NONE, 1'b0, '0);
        add_line("@@ -1 +1 @@", TAIL_NONE, 1'b1, mk_word(KIND_HEADER, 1, 1, 1, 1, 1'b0));
        add_line(" ctx", TAIL_NONE, 1'b1, mk_word(KIND_SAME, 0, 0, 0, 0, 1'b1));
        // saturating numbers, both counts zero: done at once, stays in header mode
        add_line("@@ -4294967295,0 +99999999999,0 @@", TAIL_NONE, 1'b1,
                 mk_word(KIND_HEADER, NUM_MAX, 0, NUM_MAX, 0, 1'b1));
        add_line("@@ -0,0 +0,0 @@", TAIL_NONE, 1'b1, mk_word(KIND_HEADER, 0, 0, 0, 0, 1'b1));
        add_line("@@ -5,2 +7,0 @@", TAIL_NONE, 1'b1, mk_word(KIND_HEADER, 5, 2, 8, 0, 1'b0));
        add_line("-a", TAIL_NONE, 1'b0, '0);
        add_line("-", TAIL_NONE, 1'b1, mk_word(KIND_DEL, 0, 0, 0, 0, 1'b1));
        add_line("@@ -1 +1 @@", TAIL_NONE, 1'b0, '0);
        add_line("+", TAIL_NONE, 1'b0, '0);
        // second insert overdraws the after count
        add_line("+", TAIL_NONE, 1'b1, mk_word(KIND_BAD, 0, 0, 0, 0, 1'b0));
        // rejected headers: carriage return, trailing text, empty, missing space
        add_line("@@ -1,1 +1,1 @@", 8'd13, 1'b0, '0);
        add_line("@@ -1,1 +1,1 @@ x", TAIL_NONE, 1'b0, '0);
        add_line("", TAIL_NONE, 1'b0, '0);
        add_line("@@-1 +1 @@", TAIL_NONE, 1'b0, '0);
        add_line("@@ -2,3 +2,3 @@", TAIL_NONE, 1'b0, '0);
        add_line("", TAIL_NONE, 1'b1, mk_word(KIND_BAD, 0, 0, 0, 0, 1'b0));
        add_line("@@ -9 +9 @@", TAIL_NONE, 1'b0, '0);
        add_line("", 8'hFF, 1'b1, mk_word(KIND_BAD, 0, 0, 0, 0, 1'b0));
        add_line("@@ -1,0 +0,1 @@", TAIL_NONE, 1'b0, '0);
        add_line("", 8'h00, 1'b1, mk_word(KIND_BAD, 0, 0, 0, 0, 1'b0));
        add_line("@@ -3 +1,2 @@", TAIL_NONE, 1'b0, '0);
        add_line(" a", TAIL_NONE, 1'b0, '0);
        add_line("+b", TAIL_NONE, 1'b0, '0);

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_lines[k]) begin
            push_str(dir_lines[k].text);
            if (dir_lines[k].tail != TAIL_NONE) add_byte(8'(dir_lines[k].tail));
            send_line(dir_lines[k].typed, dir_lines[k].word);
        end

        // sender pause: let every owed word drain
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (line_words_due.size() != 0) @(posedge i_clk);

        // random part: hunks, file-name lines and byte noise
        dir_bytes = bytes_sent;
        while (bytes_sent < dir_bytes + RANDOM_BYTES) begin
            rb = bytes_sent - dir_bytes;
            if (rb > 200 && !hold_asked) begin
                // long receiver hold-off while bytes keep coming, so the queue fills
                long_hold_req = 1'b1;
                hold_asked    = 1'b1;
            end
            if (rb > 430 && !long_hold_req) begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            sel = $urandom_range(0, 9);
            if (sel == 0) begin
                n = $urandom_range(0, 10);
                repeat (n) add_byte(any_text_byte());
                send_line(1'b0, '0);
            end else if (sel == 1) begin
                push_str($urandom_range(0, 1) ? "--- a/src.c" : "+++ b/src.c");
                send_line(1'b0, '0);
            end else begin
                random_hunk();
            end
        end

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (line_words_due.size() != 0) @(posedge i_clk);
        // then wait on to catch any stray word
        repeat (16) @(posedge i_clk);

        if (mismatches == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/uhp_pkg.sv
rtl/core/uhp_front.sv
rtl/core/uhp_queue.sv
rtl/core/uhp_back.sv
rtl/core/unified_diff_hunk_parser_unit.sv
sim/tb_top.sv
